// ----- hdl/sleu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sleu_pkg: shared types and codes of the string literal unescaper
// Field widths, result kinds, error codes and the request/result structs.
// ----------------------------------------------------------------------------
package sleu_pkg;

   localparam int CpWidth   = 21;
   localparam int KindWidth = 2;
   localparam int ErrWidth  = 3;

   // Result kinds
   localparam logic [KindWidth-1:0] KIND_CHAR  = 2'd0;
   localparam logic [KindWidth-1:0] KIND_CLOSE = 2'd1;
   localparam logic [KindWidth-1:0] KIND_ERROR = 2'd2;

   // Error codes
   localparam logic [ErrWidth-1:0] ERR_CONTROL      = 3'd0;
   localparam logic [ErrWidth-1:0] ERR_INCOMPLETE   = 3'd1;
   localparam logic [ErrWidth-1:0] ERR_BAD_ESCAPE   = 3'd2;
   localparam logic [ErrWidth-1:0] ERR_HEX_NEEDED   = 3'd3;
   localparam logic [ErrWidth-1:0] ERR_MISSING_LOW  = 3'd4;
   localparam logic [ErrWidth-1:0] ERR_BAD_LOW      = 3'd5;
   localparam logic [ErrWidth-1:0] ERR_LONE_LOW     = 3'd6;
   localparam logic [ErrWidth-1:0] ERR_UNTERMINATED = 3'd7;

   // Characters of interest
   localparam logic [CpWidth-1:0] CH_BACKSLASH  = 21'h5C;
   localparam logic [CpWidth-1:0] CH_APOSTROPHE = 21'h27;
   localparam logic [CpWidth-1:0] CH_QUOTE      = 21'h22;
   localparam logic [CpWidth-1:0] CH_B          = 21'h62;
   localparam logic [CpWidth-1:0] CH_F          = 21'h66;
   localparam logic [CpWidth-1:0] CH_N          = 21'h6E;
   localparam logic [CpWidth-1:0] CH_R          = 21'h72;
   localparam logic [CpWidth-1:0] CH_T          = 21'h74;
   localparam logic [CpWidth-1:0] CH_U          = 21'h75;
   localparam logic [CpWidth-1:0] CH_DEL        = 21'h7F;
   localparam logic [CpWidth-1:0] CH_SPACE      = 21'h20;
   localparam logic [CpWidth-1:0] CP_SUPPLEMENT = 21'h10000;

   // Top six bits of a 16-bit unit that mark high and low surrogates
   localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
   localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;

   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               start_req;
      logic               end_of_text;
   } sleu_item_type;

   typedef struct packed {
      logic [KindWidth-1:0] kind;
      logic [CpWidth-1:0]   char_out;
      logic [ErrWidth-1:0]  error_code;
   } sleu_result_type;

endpackage : sleu_pkg
`default_nettype wire

// ----- hdl/sleu_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sleu_req_if / sleu_rsp_if: valid/ready channels of the unescaper
// Request channel carries code points, response channel carries results.
// ----------------------------------------------------------------------------
interface sleu_req_if;
   import sleu_pkg::*;
   logic               valid;
   logic               ready;
   logic [CpWidth-1:0] code_point;
   logic               start_req;
   logic               end_of_text;

   modport source (output valid, output code_point, output start_req,
                   output end_of_text, input ready);
   modport sink   (input valid, input code_point, input start_req,
                   input end_of_text, output ready);
endinterface : sleu_req_if

interface sleu_rsp_if;
   import sleu_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KindWidth-1:0] kind;
   logic [CpWidth-1:0]   char_out;
   logic [ErrWidth-1:0]  error_code;

   modport source (output valid, output kind, output char_out,
                   output error_code, input ready);
   modport sink   (input valid, input kind, input char_out,
                   input error_code, output ready);
endinterface : sleu_rsp_if
`default_nettype wire

// ----- hdl/sleu_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sleu_core: decode state machine and result register
// Takes one request per cycle from the input register unless the output
// register stalls, updates the literal state and loads at most one result into it.
// ----------------------------------------------------------------------------
module sleu_core
   import sleu_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   input  wire sleu_item_type   in_item,
   output logic                 in_ready,
   output logic                 out_valid,
   output sleu_result_type      out_result,
   input  wire logic            out_ready
);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_TEXT,
      MODE_ESCAPE,
      MODE_HEX_HI,
      MODE_WANT_BS,
      MODE_WANT_U,
      MODE_HEX_LO
   } mode_type;

   mode_type           mode_ff,   mode_in;
   logic [CpWidth-1:0] quote_ff,  quote_in;
   logic [15:0]        accum_ff,  accum_in;
   logic [1:0]         count_ff,  count_in;
   logic [9:0]         high_ff,   high_in;
   logic               valid_ff,  valid_in;
   sleu_result_type    result_ff, result_in;

   logic               take;
   logic               emit;
   sleu_result_type    res;
   logic [CpWidth-1:0] c;
   logic [3:0]         hex_val;
   logic               hex_ok;
   logic [15:0]        unit;
   logic               unit_done;

   assign c        = in_item.code_point;
   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   // Hex digit decode: ASCII 0-9, a-f, A-F only
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (c >= 21'h30 && c <= 21'h39) begin
         hex_val = c[3:0];
      end else if ((c >= 21'h61 && c <= 21'h66) || (c >= 21'h41 && c <= 21'h46)) begin
         hex_val = c[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign unit      = {accum_ff[11:0], hex_val};
   assign unit_done = (count_ff == 2'd3);

   always_comb begin
      mode_in  = mode_ff;
      quote_in = quote_ff;
      accum_in = accum_ff;
      count_in = count_ff;
      high_in  = high_ff;
      emit     = 1'b0;
      res      = '{kind: KIND_CHAR, char_out: '0, error_code: ERR_CONTROL};

      if (in_item.start_req) begin
         mode_in  = MODE_TEXT;
         quote_in = c;
         accum_in = '0;
         count_in = '0;
         high_in  = '0;
      end else if (mode_ff == MODE_IDLE) begin
         mode_in = MODE_IDLE;
      end else if (in_item.end_of_text) begin
         emit     = 1'b1;
         mode_in  = MODE_IDLE;
         res.kind = KIND_ERROR;
         case (mode_ff)
            MODE_TEXT:   res.error_code = ERR_UNTERMINATED;
            MODE_ESCAPE: res.error_code = ERR_INCOMPLETE;
            MODE_HEX_HI: res.error_code = ERR_HEX_NEEDED;
            MODE_HEX_LO: res.error_code = ERR_HEX_NEEDED;
            default:     res.error_code = ERR_MISSING_LOW;
         endcase
      end else begin
         case (mode_ff)
            MODE_TEXT: begin
               if (c == quote_ff) begin
                  emit     = 1'b1;
                  mode_in  = MODE_IDLE;
                  res.kind = KIND_CLOSE;
               end else if (c < CH_SPACE || c == CH_DEL) begin
                  emit           = 1'b1;
                  mode_in        = MODE_IDLE;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_CONTROL;
               end else if (c == CH_BACKSLASH) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  emit         = 1'b1;
                  res.char_out = c;
               end
            end
            MODE_ESCAPE: begin
               mode_in = MODE_TEXT;
               emit    = 1'b1;
               if (c == CH_BACKSLASH || c == CH_APOSTROPHE || c == CH_QUOTE) begin
                  res.char_out = c;
               end else if (c == CH_B) begin
                  res.char_out = 21'h08;
               end else if (c == CH_F) begin
                  res.char_out = 21'h0C;
               end else if (c == CH_N) begin
                  res.char_out = 21'h0A;
               end else if (c == CH_R) begin
                  res.char_out = 21'h0D;
               end else if (c == CH_T) begin
                  res.char_out = 21'h09;
               end else if (c == CH_U) begin
                  emit     = 1'b0;
                  mode_in  = MODE_HEX_HI;
                  accum_in = '0;
                  count_in = '0;
               end else begin
                  mode_in        = MODE_IDLE;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_BAD_ESCAPE;
               end
            end
            MODE_HEX_HI, MODE_HEX_LO: begin
               if (!hex_ok) begin
                  emit           = 1'b1;
                  mode_in        = MODE_IDLE;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_HEX_NEEDED;
               end else begin
                  accum_in = unit;
                  count_in = count_ff + 2'd1;
                  if (unit_done && mode_ff == MODE_HEX_HI) begin
                     if (unit[15:10] == SURR_HIGH_TAG) begin
                        high_in = unit[9:0];
                        mode_in = MODE_WANT_BS;
                     end else if (unit[15:10] == SURR_LOW_TAG) begin
                        emit           = 1'b1;
                        mode_in        = MODE_IDLE;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_LONE_LOW;
                     end else begin
                        emit         = 1'b1;
                        mode_in      = MODE_TEXT;
                        res.char_out = {5'd0, unit};
                     end
                  end else if (unit_done) begin
                     emit = 1'b1;
                     if (unit[15:10] != SURR_LOW_TAG) begin
                        mode_in        = MODE_IDLE;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_BAD_LOW;
                     end else begin
                        mode_in      = MODE_TEXT;
                        res.char_out = CP_SUPPLEMENT + {1'b0, high_ff, unit[9:0]};
                     end
                  end
               end
            end
            MODE_WANT_BS: begin
               if (c != CH_BACKSLASH) begin
                  emit           = 1'b1;
                  mode_in        = MODE_IDLE;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_MISSING_LOW;
               end else begin
                  mode_in = MODE_WANT_U;
               end
            end
            MODE_WANT_U: begin
               if (c != CH_U) begin
                  emit           = 1'b1;
                  mode_in        = MODE_IDLE;
                  res.kind       = KIND_ERROR;
                  res.error_code = ERR_MISSING_LOW;
               end else begin
                  mode_in  = MODE_HEX_LO;
                  accum_in = '0;
                  count_in = '0;
               end
            end
            default: begin
               mode_in = MODE_IDLE;
            end
         endcase
      end
   end

   // Load a new result on a taken request, drop the old one once delivered
   always_comb begin
      result_in = result_ff;
      valid_in  = valid_ff && !out_ready;
      if (take) begin
         valid_in = emit;
         if (emit) begin
            result_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         quote_ff <= '0;
         accum_ff <= '0;
         count_ff <= '0;
         high_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (take) begin
            mode_ff  <= mode_in;
            quote_ff <= quote_in;
            accum_ff <= accum_in;
            count_ff <= count_in;
            high_ff  <= high_in;
         end
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule : sleu_core
`default_nettype wire

// ----- hdl/string_literal_unescaper_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// string_literal_unescaper_unit: quoted string literal decoder
// Decodes a quoted literal one code point per request: plain characters,
// backslash escapes and \u escapes with surrogate pairs, close and errors.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                               Handshake
//   --------  ---------  ------------------------------------  -----------
//   req_if    in         code_point, start_req, end_of_text    valid/ready
//   rsp_if    out        kind, char_out, error_code            valid/ready
//
// Each request passes through the input register, then through the decode
// state machine into the result register. A new request is accepted every
// cycle while the result register is not stalled.
// A request that yields no result (start, backslash, hex digit, idle input)
// only updates the literal state.
// The result register stalls the decoder while it holds a result and
// rsp_if.ready is low; the input register then holds one request and
// req_if.ready drops behind it.
// Synchronous reset returns the decoder to idle and empties both registers.
// ----------------------------------------------------------------------------
module string_literal_unescaper_unit
   import sleu_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   sleu_req_if.sink   req_if,
   sleu_rsp_if.source rsp_if
);

   logic            in_valid_ff, in_valid_in;
   sleu_item_type   in_item_ff,  in_item_in;
   logic            core_ready;
   logic            core_valid;
   sleu_result_type core_result;

   // Input register: refill whenever it is empty or the decoder takes it
   assign req_if.ready = !in_valid_ff || core_ready;

   always_comb begin
      in_valid_in = in_valid_ff && !core_ready;
      in_item_in  = in_item_ff;
      if (req_if.valid && req_if.ready) begin
         in_valid_in = 1'b1;
         in_item_in  = '{code_point:  req_if.code_point,
                         start_req:   req_if.start_req,
                         end_of_text: req_if.end_of_text};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_item_ff <= in_item_in;
   end

   // Decode state machine and result register
   sleu_core u_core (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (in_valid_ff),
      .in_item    (in_item_ff),
      .in_ready   (core_ready),
      .out_valid  (core_valid),
      .out_result (core_result),
      .out_ready  (rsp_if.ready)
   );

   assign rsp_if.valid      = core_valid;
   assign rsp_if.kind       = core_result.kind;
   assign rsp_if.char_out   = core_result.char_out;
   assign rsp_if.error_code = core_result.error_code;

endmodule : string_literal_unescaper_unit
`default_nettype wire

// ----- hdl/sleu_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sleu_checker: port-level checks of the unescaper
// Watches the response channel for field consistency and reset behavior.
// ----------------------------------------------------------------------------
module sleu_checker
   import sleu_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic [KindWidth-1:0] rsp_kind,
   input wire logic [CpWidth-1:0]   rsp_char_out,
   input wire logic [ErrWidth-1:0]  rsp_error_code
);

   // No result may survive a reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Close and error results carry no character
   a_char_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_CHAR |-> rsp_char_out == '0)
      else $error("character set on a non-character result");

   // Only error results carry an error code
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_ERROR |-> rsp_error_code == '0)
      else $error("error code set on a non-error result");

   // A stalled result holds
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_char_out) && $stable(rsp_error_code))
      else $error("stalled response changed");

endmodule : sleu_checker

bind string_literal_unescaper_unit sleu_checker u_sleu_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_kind       (rsp_if.kind),
   .rsp_char_out   (rsp_if.char_out),
   .rsp_error_code (rsp_if.error_code)
);
`default_nettype wire
